FILE: rtl/core/trtd_pkg.sv
// shared types, constants and pixel decode functions for the tiled texture decoder
package trtd_pkg;

  localparam int MAX_DIMENSION_DEF   = 1024;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int QUEUE_DEPTH         = 2;

  localparam int DIM_W     = 11;
  localparam int POS_W     = 10;
  localparam int ADDR_W    = 20;
  localparam int WORD_W    = 16;
  localparam int INDEX_W   = 8;
  localparam int RGB_W     = 24;
  localparam int ARGB_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic {
    OP_PALETTE_WRITE = 1'b0,
    OP_TEXEL         = 1'b1
  } opcode_t;

  typedef enum logic {
    FMT_RGB5A3 = 1'b0,
    FMT_CI8    = 1'b1
  } format_t;

  typedef struct packed {
    opcode_t             op;
    format_t             fmt;
    logic [INDEX_W-1:0]  pal_index;
    logic [WORD_W-1:0]   pal_word;
    logic [WORD_W-1:0]   texel_word;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [DIM_W-1:0]    width;
    logic                last;
  } queue_item_t;

  function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
    return {w[7:0], w[15:8]};
  endfunction

  // floor(c * 255 / 31)
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [7:0] e;
    case (c)
      5'd0:  e = 8'h00; 5'd1:  e = 8'h08; 5'd2:  e = 8'h10; 5'd3:  e = 8'h18;
      5'd4:  e = 8'h20; 5'd5:  e = 8'h29; 5'd6:  e = 8'h31; 5'd7:  e = 8'h39;
      5'd8:  e = 8'h41; 5'd9:  e = 8'h4A; 5'd10: e = 8'h52; 5'd11: e = 8'h5A;
      5'd12: e = 8'h62; 5'd13: e = 8'h6A; 5'd14: e = 8'h73; 5'd15: e = 8'h7B;
      5'd16: e = 8'h83; 5'd17: e = 8'h8B; 5'd18: e = 8'h94; 5'd19: e = 8'h9C;
      5'd20: e = 8'hA4; 5'd21: e = 8'hAC; 5'd22: e = 8'hB4; 5'd23: e = 8'hBD;
      5'd24: e = 8'hC5; 5'd25: e = 8'hCD; 5'd26: e = 8'hD5; 5'd27: e = 8'hDE;
      5'd28: e = 8'hE6; 5'd29: e = 8'hEE; 5'd30: e = 8'hF6;
      default: e = 8'hFF;
    endcase
    return e;
  endfunction

  function automatic logic [7:0] expand4(input logic [3:0] c);
    return {c, c};
  endfunction

  // floor(c * 255 / 7)
  function automatic logic [7:0] expand3(input logic [2:0] c);
    logic [7:0] e;
    case (c)
      3'd0: e = 8'h00; 3'd1: e = 8'h24; 3'd2: e = 8'h48; 3'd3: e = 8'h6D;
      3'd4: e = 8'h91; 3'd5: e = 8'hB6; 3'd6: e = 8'hDA;
      default: e = 8'hFF;
    endcase
    return e;
  endfunction

  // floor(c * a / 255) via reciprocal, exact for 16-bit products
  function automatic logic [7:0] blend_black(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] t;
    logic [16:0] s;
    p = c * a;
    t = {1'b0, p} + 17'd1;
    s = t + {8'b0, t[16:8]};
    return s[15:8];
  endfunction

  function automatic logic [RGB_W-1:0] decode_rgb5a3(input logic [WORD_W-1:0] v);
    logic [7:0] a;
    logic [RGB_W-1:0] rgb;
    if (v[15]) begin
      rgb = {expand5(v[14:10]), expand5(v[9:5]), expand5(v[4:0])};
    end else begin
      a = expand3(v[14:12]);
      rgb = {blend_black(expand4(v[11:8]), a), blend_black(expand4(v[7:4]), a),
             blend_black(expand4(v[3:0]), a)};
    end
    return rgb;
  endfunction

endpackage

FILE: rtl/core/trtd_front.sv
// front end: configuration registers, tile walk counters and queue push
module trtd_front #(
  parameter int MAX_DIMENSION = trtd_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [trtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trtd_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [trtd_pkg::INDEX_W-1:0]   in_palette_index,
  input  logic [trtd_pkg::WORD_W-1:0]    in_palette_word,
  input  logic [trtd_pkg::WORD_W-1:0]    in_texel_word,
  input  logic                           queue_full,
  output logic                           push,
  output trtd_pkg::queue_item_t          push_item
);

  localparam int DW = trtd_pkg::DIM_W;
  localparam int PW = trtd_pkg::POS_W;

  trtd_pkg::format_t fmt_r;
  logic [DW-1:0]     width_cfg_r;
  logic [DW-1:0]     height_cfg_r;

  logic [2:0]    col_r, col_nxt;
  logic [1:0]    row_r, row_nxt;
  logic [PW-1:0] tile_left_r, tile_left_nxt;
  logic [PW-1:0] tile_top_r, tile_top_nxt;

  logic [3:0]    tw;
  logic [DW-1:0] w_sat, w_eff, h_sat, h_eff;
  logic [DW-1:0] w_mask, h_mask;
  logic          row_end, tile_end, band_end, last;
  logic          accept, is_texel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r        <= trtd_pkg::FMT_RGB5A3;
      width_cfg_r  <= DW'(8);
      height_cfg_r <= DW'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        trtd_pkg::CFG_TEXTURE_FORMAT: fmt_r <= trtd_pkg::format_t'(cfg_wdata[0]);
        trtd_pkg::CFG_IMAGE_WIDTH:    width_cfg_r <= cfg_wdata[DW-1:0];
        trtd_pkg::CFG_IMAGE_HEIGHT:   height_cfg_r <= cfg_wdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions: saturate, clear low bits, at least one tile
  always_comb begin
    tw     = (fmt_r == trtd_pkg::FMT_CI8) ? 4'd8 : 4'd4;
    w_sat  = (int'(width_cfg_r) > MAX_DIMENSION) ? DW'(MAX_DIMENSION) : width_cfg_r;
    h_sat  = (int'(height_cfg_r) > MAX_DIMENSION) ? DW'(MAX_DIMENSION) : height_cfg_r;
    w_mask = w_sat & ~(DW'(tw) - DW'(1));
    h_mask = h_sat & ~DW'(3);
    w_eff  = (w_mask == '0) ? DW'(tw) : w_mask;
    h_eff  = (h_mask == '0) ? DW'(4) : h_mask;
  end

  always_comb begin
    row_end  = ({1'b0, col_r} + 4'd1) >= tw;
    tile_end = row_end && (row_r == 2'd3);
    band_end = tile_end && (({1'b0, tile_left_r} + DW'(tw)) >= w_eff);
    last     = band_end && (({1'b0, tile_top_r} + DW'(4)) >= h_eff);

    col_nxt       = col_r;
    row_nxt       = row_r;
    tile_left_nxt = tile_left_r;
    tile_top_nxt  = tile_top_r;
    if (!row_end) begin
      col_nxt = col_r + 3'd1;
    end else if (!tile_end) begin
      col_nxt = '0;
      row_nxt = row_r + 2'd1;
    end else begin
      col_nxt = '0;
      row_nxt = '0;
      if (!band_end) begin
        tile_left_nxt = tile_left_r + PW'(tw);
      end else begin
        tile_left_nxt = '0;
        tile_top_nxt  = last ? '0 : tile_top_r + PW'(4);
      end
    end
  end

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign is_texel = (trtd_pkg::opcode_t'(in_opcode) == trtd_pkg::OP_TEXEL);
  assign push     = accept;

  always_comb begin
    push_item.op         = trtd_pkg::opcode_t'(in_opcode);
    push_item.fmt        = fmt_r;
    push_item.pal_index  = in_palette_index;
    push_item.pal_word   = in_palette_word;
    push_item.texel_word = in_texel_word;
    push_item.x          = tile_left_r + PW'(col_r);
    push_item.y          = tile_top_r + PW'(row_r);
    push_item.width      = w_eff;
    push_item.last       = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      tile_left_r <= '0;
      tile_top_r  <= '0;
    end else if (accept && is_texel) begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      tile_left_r <= tile_left_nxt;
      tile_top_r  <= tile_top_nxt;
    end
  end

endmodule

FILE: rtl/core/trtd_queue.sv
// short fifo between the front end and the decode back end
module trtd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  trtd_pkg::queue_item_t push_item,
  input  logic                  pop,
  output trtd_pkg::queue_item_t pop_item,
  output logic                  empty,
  output logic                  full
);

  localparam int DEPTH = trtd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  trtd_pkg::queue_item_t slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign pop_item = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/trtd_back.sv
// back end: palette memory, address multiply and pixel decode pipeline
module trtd_back #(
  parameter int PALETTE_ENTRIES = trtd_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trtd_pkg::queue_item_t         pop_item,
  input  logic                          queue_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [trtd_pkg::POS_W-1:0]    out_pixel_x,
  output logic [trtd_pkg::POS_W-1:0]    out_pixel_y,
  output logic [trtd_pkg::ADDR_W-1:0]   out_pixel_address,
  output logic [trtd_pkg::ARGB_W-1:0]   out_argb,
  output logic                          out_last_pixel
);

  localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
  localparam int PW     = trtd_pkg::POS_W;
  localparam int AW     = trtd_pkg::ADDR_W;
  localparam int WW     = trtd_pkg::WORD_W;
  localparam int PROD_W = trtd_pkg::POS_W + trtd_pkg::DIM_W;

  logic [WW-1:0] palette_mem [PALETTE_ENTRIES];

  logic              s1_valid_r;
  logic [WW-1:0]     s1_pal_r;
  logic [WW-1:0]     s1_word_r;
  trtd_pkg::format_t s1_fmt_r;
  logic [PW-1:0]     s1_x_r, s1_y_r;
  logic [AW-1:0]     s1_addr_r;
  logic              s1_last_r;

  logic              s1_ready, s2_ready;
  logic              is_texel;
  logic [PROD_W-1:0] addr_nxt;
  logic [WW-1:0]     color_word;

  assign s2_ready = !out_valid || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign pop      = !queue_empty && s1_ready;
  assign is_texel = (pop_item.op == trtd_pkg::OP_TEXEL);

  assign addr_nxt = pop_item.y * pop_item.width + PROD_W'(pop_item.x);

  // palette write and registered palette read share the pop
  always_ff @(posedge clk) begin
    if (pop) begin
      if (!is_texel) begin
        palette_mem[pop_item.pal_index[IDX_W-1:0]] <= pop_item.pal_word;
      end
      s1_pal_r <= palette_mem[pop_item.texel_word[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_word_r <= pop_item.texel_word;
      s1_fmt_r  <= pop_item.fmt;
      s1_x_r    <= pop_item.x;
      s1_y_r    <= pop_item.y;
      s1_addr_r <= addr_nxt[AW-1:0];
      s1_last_r <= pop_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= pop && is_texel;
    end
  end

  assign color_word = trtd_pkg::swap_bytes((s1_fmt_r == trtd_pkg::FMT_CI8) ? s1_pal_r
                                                                           : s1_word_r);

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_pixel_x       <= s1_x_r;
      out_pixel_y       <= s1_y_r;
      out_pixel_address <= s1_addr_r;
      out_argb          <= {trtd_pkg::ALPHA_OPAQUE, trtd_pkg::decode_rgb5a3(color_word)};
      out_last_pixel    <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid_r;
    end
  end

endmodule

FILE: rtl/core/tiled_rgb5a3_texture_decoder.sv
// top level of the tiled rgb5a3 / ci8 texture decoder
// path: an accepted texel transaction passes through the fifo, the palette read stage and the decode/output stage
// throughput: one transaction per cycle while out_stall is low; a palette write takes one back-end slot
// the back end is one palette read stage and one decode/output stage behind a two-entry fifo
// reset: synchronous active-low; config returns to rgb5a3 8x4, counters to the origin
// palette contents are not cleared by reset and must be written before use
module tiled_rgb5a3_texture_decoder #(
  parameter int MAX_DIMENSION   = trtd_pkg::MAX_DIMENSION_DEF,
  parameter int PALETTE_ENTRIES = trtd_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [trtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trtd_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [trtd_pkg::INDEX_W-1:0]   in_palette_index,
  input  logic [trtd_pkg::WORD_W-1:0]    in_palette_word,
  input  logic [trtd_pkg::WORD_W-1:0]    in_texel_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [trtd_pkg::POS_W-1:0]     out_pixel_x,
  output logic [trtd_pkg::POS_W-1:0]     out_pixel_y,
  output logic [trtd_pkg::ADDR_W-1:0]    out_pixel_address,
  output logic [trtd_pkg::ARGB_W-1:0]    out_argb,
  output logic                           out_last_pixel
);

  logic                  push, pop, queue_full, queue_empty;
  trtd_pkg::queue_item_t push_item, pop_item;

  trtd_front #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_palette_index (in_palette_index),
    .in_palette_word  (in_palette_word),
    .in_texel_word    (in_texel_word),
    .queue_full       (queue_full),
    .push             (push),
    .push_item        (push_item)
  );

  trtd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  trtd_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_item          (pop_item),
    .queue_empty       (queue_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_argb          (out_argb),
    .out_last_pixel    (out_last_pixel)
  );

endmodule
